>>> design/ngtdm_accumulator_top_defines.svh
// ============================================================================
// ngtdm_accumulator_top_defines.svh
// Assertion macros shared by the NGTDM accumulator RTL.
// ============================================================================
`ifndef NGTDM_ACCUMULATOR_TOP_DEFINES_SVH
`define NGTDM_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define NGTDM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define NGTDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ngtdm_pkg.sv
// ============================================================================
// ngtdm_pkg
// Types and fixed constants of the NGTDM accumulator.
// ============================================================================
`timescale 1ns / 1ps

package ngtdm_pkg;

    localparam int LEVEL_W   = 6;
    localparam int COUNT_W   = 21;
    localparam int SUM_W     = 26;
    localparam int CFG_W     = 11;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int DIV_W     = 9;   // |x*cnt - sum| <= 8*63
    localparam int NCNT_W    = 4;   // neighbour count 0..8
    localparam int REM_W     = 3;
    localparam int RESET_DIM = 512;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    // register select is paddr[2]
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT,
        S_EVAL,
        S_DIV,
        S_TRD,
        S_TWR,
        S_FRD,
        S_FSH,
        S_ERD,
        S_ELD,
        S_EOUT
    } state_t;

    // window evaluation: centre column (0: col 1, 1: col 2) and present sides
    typedef struct packed {
        logic ctr;
        logic left;
        logic right;
        logic top;
        logic bot;
    } eval_cfg_t;

endpackage

>>> design/ngtdm_accumulator_top.sv
// ============================================================================
// ngtdm_accumulator_top
// Neighbourhood grey tone difference accumulator with per-level table output.
// ============================================================================
`timescale 1ns / 1ps
`include "ngtdm_accumulator_top_defines.svh"

// One pixel transaction at a time. A pixel takes a line store read and a
// window shift, plus a window evaluation for each window it centers (at
// most two). An evaluation is a window sum, then the bit-serial divider
// when the center has neighbours, then a read/write pair on the level
// tables; it ends after the window sum when the center is 0 or above
// LEVELS. The last pixel of a frame then sweeps the final row through the
// line store, a read and a shift per column over width+1 columns, plus one
// window evaluation per centered pixel, and emits the LEVELS results, which
// res_stall can hold. Table accesses never overlap, so no forwarding is
// needed. No clearing pass: level tables use valid bits.
module ngtdm_accumulator_top
    import ngtdm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int LEVELS     = 63
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  logic [LEVEL_W-1:0]  grey_level,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [LEVEL_W-1:0]  level_out,
    output logic [COUNT_W-1:0]  pixel_count,
    output logic [SUM_W-1:0]    diff_sum,
    output logic                last_level
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = $clog2(LEVELS);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   cfg_width_reg, cfg_width_next;
    logic [CFG_W-1:0]   cfg_height_reg, cfg_height_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [LEVELS-1:0]  tvalid_reg, tvalid_next;
    logic               pend_b_reg, pend_b_next;
    logic               fin_mode_reg, fin_mode_next;
    logic               fin_last_reg, fin_last_next;
    logic [CW:0]        fin_k_reg, fin_k_next;
    logic [LW-1:0]      lv_idx_reg, lv_idx_next;
    logic [NCNT_W-1:0]  div_n_reg, div_n_next;

    logic [LEVEL_W-1:0] x_reg, x_next;
    logic [LEVEL_W-1:0] win_reg [3][3];
    logic [LEVEL_W-1:0] win_next [3][3];
    eval_cfg_t          ev_cfg_reg, ev_cfg_next;
    logic [LW-1:0]      tidx_reg, tidx_next;
    logic [NCNT_W-1:0]  div_d_reg, div_d_next;
    logic [REM_W-1:0]   div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]   div_quo_reg, div_quo_next;
    logic [LEVEL_W-1:0] level_out_reg, level_out_next;
    logic [COUNT_W-1:0] pixel_count_reg, pixel_count_next;
    logic [SUM_W-1:0]   diff_sum_reg, diff_sum_next;
    logic               last_level_reg, last_level_next;

    // line store: two rows, slot = row parity
    logic [LEVEL_W-1:0] ls_mem [0:(2<<CW)-1];
    logic [LEVEL_W-1:0] ls_rd_a_reg, ls_rd_b_reg;
    logic [CW-1:0]      ls_col;
    logic               ls_we;

    // level tables
    logic [COUNT_W-1:0] cnt_mem [0:LEVELS-1];
    logic [SUM_W-1:0]   sum_mem [0:LEVELS-1];
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [SUM_W-1:0]   sum_rd_reg;
    logic [LW-1:0]      tbl_raddr;
    logic               tbl_we;
    logic [COUNT_W-1:0] cnt_old, cnt_new;
    logic [SUM_W-1:0]   sum_old, sum_new;
    logic [SUM_W:0]     sum_add;

    logic               cfg_we;
    logic [12:0]        wide_w, wide_h;
    logic [CW-1:0]      w_last;
    logic [RW-1:0]      h_last;
    logic               is_last;
    logic               pend_a, pend_b;
    eval_cfg_t          cfg_a, cfg_b, cfg_f;

    logic [1:0]         col_l, col_c;
    logic [DIV_W-1:0]   nb_sum;
    logic [NCNT_W-1:0]  nb_cnt;
    logic [LEVEL_W-1:0] center;
    logic [DIV_W:0]     prod, diff;
    logic               skip;
    logic [NCNT_W-1:0]  trial;
    logic               trial_ge;

    logic               do_after;
    state_t             pix_end_state, after_state;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_IDX_WIDTH:  prdata = DATA_W'(cfg_width_reg);
            REG_IDX_HEIGHT: prdata = DATA_W'(cfg_height_reg);
            default:        prdata = '0;
        endcase
    end

    // effective frame size
    assign wide_w = 13'(cfg_width_reg);
    assign wide_h = 13'(cfg_height_reg);

    always_comb
    begin
        if (cfg_width_reg == '0)
            w_last = '0;
        else if (wide_w > 13'(MAX_WIDTH))
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(cfg_width_reg - 11'd1);

        if (cfg_height_reg == '0)
            h_last = '0;
        else if (wide_h > 13'(MAX_HEIGHT))
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(cfg_height_reg - 11'd1);
    end

    assign is_last = (row_reg == h_last) && (col_reg == w_last);
    assign pend_a  = (row_reg != '0) && (col_reg != '0);
    assign pend_b  = (row_reg != '0) && (col_reg == w_last);

    assign cfg_a = '{ctr: 1'b0, left: (col_reg > CW'(1)), right: 1'b1,
                     top: (row_reg > RW'(1)), bot: 1'b1};
    assign cfg_b = '{ctr: 1'b1, left: (w_last != '0), right: 1'b0,
                     top: (row_reg > RW'(1)), bot: 1'b1};
    assign cfg_f = '{ctr: 1'b0, left: (fin_k_reg > (CW+1)'(1)),
                     right: (fin_k_reg <= {1'b0, w_last}),
                     top: (row_reg != '0), bot: 1'b0};

    // ------------------------------------------------------------------
    // window sum and difference
    // ------------------------------------------------------------------
    always_comb
    begin
        col_l  = ev_cfg_reg.ctr ? 2'd1 : 2'd0;
        col_c  = ev_cfg_reg.ctr ? 2'd2 : 2'd1;
        nb_sum = '0;
        nb_cnt = '0;
        if (ev_cfg_reg.top)
        begin
            nb_sum = nb_sum + DIV_W'(win_reg[0][col_c]);
            nb_cnt = nb_cnt + 4'd1;
            if (ev_cfg_reg.left)
            begin
                nb_sum = nb_sum + DIV_W'(win_reg[0][col_l]);
                nb_cnt = nb_cnt + 4'd1;
            end
            if (ev_cfg_reg.right)
            begin
                nb_sum = nb_sum + DIV_W'(win_reg[0][2]);
                nb_cnt = nb_cnt + 4'd1;
            end
        end
        if (ev_cfg_reg.left)
        begin
            nb_sum = nb_sum + DIV_W'(win_reg[1][col_l]);
            nb_cnt = nb_cnt + 4'd1;
        end
        if (ev_cfg_reg.right)
        begin
            nb_sum = nb_sum + DIV_W'(win_reg[1][2]);
            nb_cnt = nb_cnt + 4'd1;
        end
        if (ev_cfg_reg.bot)
        begin
            nb_sum = nb_sum + DIV_W'(win_reg[2][col_c]);
            nb_cnt = nb_cnt + 4'd1;
            if (ev_cfg_reg.left)
            begin
                nb_sum = nb_sum + DIV_W'(win_reg[2][col_l]);
                nb_cnt = nb_cnt + 4'd1;
            end
            if (ev_cfg_reg.right)
            begin
                nb_sum = nb_sum + DIV_W'(win_reg[2][2]);
                nb_cnt = nb_cnt + 4'd1;
            end
        end
    end

    assign center = win_reg[1][col_c];
    assign prod   = (DIV_W+1)'(center) * (DIV_W+1)'(nb_cnt);
    assign diff   = (prod >= (DIV_W+1)'(nb_sum)) ? prod - (DIV_W+1)'(nb_sum)
                                                 : (DIV_W+1)'(nb_sum) - prod;
    assign skip   = (center == '0) || (center > LEVEL_W'(LEVELS));

    // restoring divider step
    assign trial    = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign trial_ge = trial >= div_d_reg;

    // table update
    assign cnt_old = tvalid_reg[tidx_reg] ? cnt_rd_reg : '0;
    assign sum_old = tvalid_reg[tidx_reg] ? sum_rd_reg : '0;
    assign cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + COUNT_W'(1);
    assign sum_add = (SUM_W+1)'(sum_old) + (SUM_W+1)'(div_quo_reg);
    assign sum_new = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

    assign tbl_we    = (state_reg == S_TWR);
    assign tbl_raddr = (state_reg == S_ERD) ? lv_idx_reg : tidx_reg;
    assign ls_we     = (state_reg == S_SHIFT);
    assign ls_col    = (state_reg == S_FRD) ? fin_k_reg[CW-1:0] : col_reg;

    assign do_after = ((state_reg == S_EVAL) && skip) || (state_reg == S_TWR);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        pix_end_state = is_last ? S_FRD : S_IDLE;
        if (fin_mode_reg)
            after_state = fin_last_reg ? S_ERD : S_FRD;
        else if (pend_b_reg)
            after_state = S_EVAL;
        else
            after_state = pix_end_state;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (pix_valid) state_next = S_SHIFT;
            S_SHIFT: state_next = (pend_a || pend_b) ? S_EVAL : pix_end_state;
            S_EVAL:
            begin
                if (skip)
                    state_next = after_state;
                else if (nb_cnt == '0)
                    state_next = S_TRD;
                else
                    state_next = S_DIV;
            end
            S_DIV:   if (div_n_reg == NCNT_W'(DIV_W - 1)) state_next = S_TRD;
            S_TRD:   state_next = S_TWR;
            S_TWR:   state_next = after_state;
            S_FRD:   state_next = S_FSH;
            S_FSH:   state_next = (fin_k_reg != '0) ? S_EVAL : S_FRD;
            S_ERD:   state_next = S_ELD;
            S_ELD:   state_next = S_EOUT;
            S_EOUT:
            begin
                if (!res_stall)
                    state_next = last_level_reg ? S_IDLE : S_ERD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and control registers
    // ------------------------------------------------------------------
    always_comb
    begin
        cfg_width_next   = cfg_width_reg;
        cfg_height_next  = cfg_height_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        tvalid_next      = tvalid_reg;
        pend_b_next      = pend_b_reg;
        fin_mode_next    = fin_mode_reg;
        fin_last_next    = fin_last_reg;
        fin_k_next       = fin_k_reg;
        lv_idx_next      = lv_idx_reg;
        div_n_next       = div_n_reg;
        x_next           = x_reg;
        win_next         = win_reg;
        ev_cfg_next      = ev_cfg_reg;
        tidx_next        = tidx_reg;
        div_d_next       = div_d_reg;
        div_rem_next     = div_rem_reg;
        div_quo_next     = div_quo_reg;
        level_out_next   = level_out_reg;
        pixel_count_next = pixel_count_reg;
        diff_sum_next    = diff_sum_reg;
        last_level_next  = last_level_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    if (paddr[2] == REG_IDX_WIDTH)
                        cfg_width_next = pwdata[CFG_W-1:0];
                    else
                        cfg_height_next = pwdata[CFG_W-1:0];
                    row_next    = '0;
                    col_next    = '0;
                    tvalid_next = '0;
                end
                if (pix_valid)
                begin
                    x_next        = grey_level;
                    fin_mode_next = 1'b0;
                end
            end
            S_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_next[i][0] = win_reg[i][1];
                    win_next[i][1] = win_reg[i][2];
                end
                win_next[0][2] = (row_reg > RW'(1)) ? ls_rd_a_reg : '0;
                win_next[1][2] = (row_reg != '0) ? ls_rd_b_reg : '0;
                win_next[2][2] = x_reg;
                if (pend_a)
                begin
                    ev_cfg_next = cfg_a;
                    pend_b_next = pend_b;
                end
                else if (pend_b)
                begin
                    ev_cfg_next = cfg_b;
                    pend_b_next = 1'b0;
                end
            end
            S_EVAL:
            begin
                tidx_next    = LW'(center - LEVEL_W'(1));
                div_d_next   = nb_cnt;
                div_rem_next = '0;
                div_n_next   = '0;
                div_quo_next = (nb_cnt == '0) ? '0 : diff[DIV_W-1:0];
            end
            S_DIV:
            begin
                div_rem_next = trial_ge ? REM_W'(trial - div_d_reg) : REM_W'(trial);
                div_quo_next = {div_quo_reg[DIV_W-2:0], trial_ge};
                div_n_next   = div_n_reg + NCNT_W'(1);
            end
            S_TWR:
            begin
                tvalid_next[tidx_reg] = 1'b1;
            end
            S_FSH:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_next[i][0] = win_reg[i][1];
                    win_next[i][1] = win_reg[i][2];
                end
                win_next[0][2] = ls_rd_b_reg;
                win_next[1][2] = ls_rd_a_reg;
                win_next[2][2] = '0;
                ev_cfg_next    = cfg_f;
                fin_last_next  = (fin_k_reg == ({1'b0, w_last} + (CW+1)'(1)));
                fin_k_next     = fin_k_reg + (CW+1)'(1);
            end
            S_ELD:
            begin
                level_out_next   = LEVEL_W'(lv_idx_reg) + LEVEL_W'(1);
                pixel_count_next = tvalid_reg[lv_idx_reg] ? cnt_rd_reg : '0;
                diff_sum_next    = tvalid_reg[lv_idx_reg] ? sum_rd_reg : '0;
                last_level_next  = (lv_idx_reg == LW'(LEVELS - 1));
            end
            S_EOUT:
            begin
                if (!res_stall)
                begin
                    if (last_level_reg)
                    begin
                        tvalid_next = '0;
                        row_next    = '0;
                        col_next    = '0;
                    end
                    else
                    begin
                        lv_idx_next = lv_idx_reg + LW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase

        // second window of a row end
        if (do_after && !fin_mode_reg && pend_b_reg)
        begin
            ev_cfg_next = cfg_b;
            pend_b_next = 1'b0;
        end

        // pixel done: advance position or start the last-row sweep
        if (((state_reg == S_SHIFT) && !pend_a && !pend_b) ||
            (do_after && !fin_mode_reg && !pend_b_reg))
        begin
            if (is_last)
            begin
                fin_mode_next = 1'b1;
                fin_k_next    = '0;
                lv_idx_next   = '0;
            end
            else if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_width_reg  <= CFG_W'(RESET_DIM);
            cfg_height_reg <= CFG_W'(RESET_DIM);
            row_reg        <= '0;
            col_reg        <= '0;
            tvalid_reg     <= '0;
            pend_b_reg     <= 1'b0;
            fin_mode_reg   <= 1'b0;
            fin_last_reg   <= 1'b0;
            fin_k_reg      <= '0;
            lv_idx_reg     <= '0;
            div_n_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_width_reg  <= cfg_width_next;
            cfg_height_reg <= cfg_height_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            tvalid_reg     <= tvalid_next;
            pend_b_reg     <= pend_b_next;
            fin_mode_reg   <= fin_mode_next;
            fin_last_reg   <= fin_last_next;
            fin_k_reg      <= fin_k_next;
            lv_idx_reg     <= lv_idx_next;
            div_n_reg      <= div_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        win_reg         <= win_next;
        ev_cfg_reg      <= ev_cfg_next;
        tidx_reg        <= tidx_next;
        div_d_reg       <= div_d_next;
        div_rem_reg     <= div_rem_next;
        div_quo_reg     <= div_quo_next;
        level_out_reg   <= level_out_next;
        pixel_count_reg <= pixel_count_next;
        diff_sum_reg    <= diff_sum_next;
        last_level_reg  <= last_level_next;
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ls_we)
            ls_mem[{row_reg[0], col_reg}] <= x_reg;
        ls_rd_a_reg <= ls_mem[{row_reg[0], ls_col}];
        ls_rd_b_reg <= ls_mem[{~row_reg[0], ls_col}];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            cnt_mem[tidx_reg] <= cnt_new;
            sum_mem[tidx_reg] <= sum_new;
        end
        cnt_rd_reg <= cnt_mem[tbl_raddr];
        sum_rd_reg <= sum_mem[tbl_raddr];
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign pix_stall   = (state_reg != S_IDLE);
    assign res_valid   = (state_reg == S_EOUT);
    assign level_out   = level_out_reg;
    assign pixel_count = pixel_count_reg;
    assign diff_sum    = diff_sum_reg;
    assign last_level  = last_level_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `NGTDM_ASSERT_NOW(a_emit_blocks_pixels, res_valid, pix_stall, "pixel taken during emit")
    `NGTDM_ASSERT_NOW(a_last_top, res_valid && last_level, level_out == LEVEL_W'(LEVELS), "bad last")
    `NGTDM_ASSERT_NOW(a_div_nonzero, state_reg == S_DIV, div_d_reg != '0, "divide by zero count")
    `NGTDM_ASSERT_NEXT(a_acc_shift, pix_valid && !pix_stall, state_reg == S_SHIFT, "no shift")

endmodule
